@@ sv/iirbq_pkg.sv @@
// ----------------------------------------------------------------------------
// iirbq_pkg
// Shared widths, register indexes, reset values, types and helpers for the
// direct form II biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package iirbq_pkg;

  // Data widths
  localparam int SAMPLE_BITS = 8;
  localparam int STATE_BITS  = 16;
  localparam int COEF_BITS   = 9;
  localparam int FRAC_BITS   = 7;
  localparam int PROD_BITS   = COEF_BITS + STATE_BITS;
  localparam int TERM_BITS   = PROD_BITS - FRAC_BITS;
  // x plus two shifted terms, or three shifted terms, fit with two bits of headroom
  localparam int ACC_BITS    = TERM_BITS + 2;

  // Configuration port
  localparam int NUM_REGS   = 5;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;
  localparam int INDEX_BITS = 3;

  // Register indexes
  localparam logic [INDEX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_A2 = 3'd4;

  // Coefficient reset values (Q2.7)
  localparam logic signed [COEF_BITS-1:0] RST_B0 = 9'sd8;
  localparam logic signed [COEF_BITS-1:0] RST_B1 = 9'sd17;
  localparam logic signed [COEF_BITS-1:0] RST_B2 = 9'sd8;
  localparam logic signed [COEF_BITS-1:0] RST_A1 = -9'sd147;
  localparam logic signed [COEF_BITS-1:0] RST_A2 = 9'sd52;

  // Accumulator operations of the MAC unit
  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_LOAD_X = 3'd1;
  localparam logic [2:0] ACC_LOAD_P = 3'd2;
  localparam logic [2:0] ACC_ADD_P  = 3'd3;
  localparam logic [2:0] ACC_SUB_P  = 3'd4;

  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef struct packed {
    logic       prod_en;
    logic [2:0] acc_op;
  } mac_ctrl_t;

  // Clamp an accumulator value to the signed state range
  function automatic state_t sat_state(input acc_t v);
    logic all_one;
    logic any_one;
    all_one = &v[ACC_BITS-1:STATE_BITS-1];
    any_one = |v[ACC_BITS-1:STATE_BITS-1];
    if (all_one || !any_one) begin
      sat_state = v[STATE_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/iirbq_if.sv @@
// ----------------------------------------------------------------------------
// iirbq_in_if / iirbq_out_if
// Valid/ready request channels for input samples and filtered samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirbq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [iirbq_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirbq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iirbq_pkg::STATE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ sv/iirbq_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// iirbq_cfg_regs
// APB-style coefficient register file; five Q2.7 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module iirbq_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [iirbq_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [iirbq_pkg::DATA_BITS-1:0]    pwdata,
  output logic      [iirbq_pkg::DATA_BITS-1:0]    prdata,
  output logic                                    pready,
  output iirbq_pkg::coef_set_t                    coefs
);

  logic [iirbq_pkg::INDEX_BITS-1:0] index;
  logic                             wr_en;
  iirbq_pkg::coef_t                 wr_val;
  iirbq_pkg::coef_t                 rd_val;

  assign index  = paddr[iirbq_pkg::ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[iirbq_pkg::COEF_BITS-1:0];
  assign pready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= iirbq_pkg::RST_B0;
      coefs.b1 <= iirbq_pkg::RST_B1;
      coefs.b2 <= iirbq_pkg::RST_B2;
      coefs.a1 <= iirbq_pkg::RST_A1;
      coefs.a2 <= iirbq_pkg::RST_A2;
    end else if (wr_en) begin
      unique case (index)
        iirbq_pkg::REG_B0: coefs.b0 <= wr_val;
        iirbq_pkg::REG_B1: coefs.b1 <= wr_val;
        iirbq_pkg::REG_B2: coefs.b2 <= wr_val;
        iirbq_pkg::REG_A1: coefs.a1 <= wr_val;
        iirbq_pkg::REG_A2: coefs.a2 <= wr_val;
        default: ;
      endcase
    end
  end

  // Read mux, sign-extended to the bus width
  always_comb begin
    unique case (index)
      iirbq_pkg::REG_B0: rd_val = coefs.b0;
      iirbq_pkg::REG_B1: rd_val = coefs.b1;
      iirbq_pkg::REG_B2: rd_val = coefs.b2;
      iirbq_pkg::REG_A1: rd_val = coefs.a1;
      iirbq_pkg::REG_A2: rd_val = coefs.a2;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = {{(iirbq_pkg::DATA_BITS-iirbq_pkg::COEF_BITS){rd_val[iirbq_pkg::COEF_BITS-1]}},
                   rd_val};

endmodule

`default_nettype wire

@@ sv/iirbq_mac.sv @@
// ----------------------------------------------------------------------------
// iirbq_mac
// Shared multiplier with a product register, floor shift by the fraction
// width and a single accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module iirbq_mac (
  input  wire logic                                   clk,
  input  wire iirbq_pkg::mac_ctrl_t                   ctrl,
  input  wire iirbq_pkg::coef_t                       coef,
  input  wire iirbq_pkg::state_t                      operand,
  input  wire logic signed [iirbq_pkg::SAMPLE_BITS-1:0] x,
  output iirbq_pkg::acc_t                             acc
);

  logic signed [iirbq_pkg::PROD_BITS-1:0] prod;
  iirbq_pkg::acc_t                        term;
  iirbq_pkg::acc_t                        x_ext;

  // Product register
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= coef * operand;
    end
  end

  // Arithmetic shift right: dropping the low bits is floor rounding
  assign term = {{(iirbq_pkg::ACC_BITS-iirbq_pkg::TERM_BITS){prod[iirbq_pkg::PROD_BITS-1]}},
                 prod[iirbq_pkg::PROD_BITS-1:iirbq_pkg::FRAC_BITS]};
  assign x_ext = {{(iirbq_pkg::ACC_BITS-iirbq_pkg::SAMPLE_BITS){x[iirbq_pkg::SAMPLE_BITS-1]}}, x};

  // Accumulator
  always_ff @(posedge clk) begin
    unique case (ctrl.acc_op)
      iirbq_pkg::ACC_LOAD_X: acc <= x_ext;
      iirbq_pkg::ACC_LOAD_P: acc <= term;
      iirbq_pkg::ACC_ADD_P:  acc <= acc + term;
      iirbq_pkg::ACC_SUB_P:  acc <= acc - term;
      default:               acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/iir_biquad_direct_form_two_unit.sv @@
// ----------------------------------------------------------------------------
// iir_biquad_direct_form_two_unit
// Second-order direct form II IIR filter with one shared multiplier.
// ----------------------------------------------------------------------------
// One 8-bit signed sample in, one 16-bit saturated sample out per request.
// After a sample is accepted, six steps on the single shared multiplier and
// accumulator compute w = x - a1*w1 - a2*w2 and y = b0*w + b1*w1 + b2*w2
// (each product floor-shifted by 7); a finishing state saturates y into the
// output register and shifts the delay line. A new sample is taken only when
// the last is finished, as the five products share one multiplier. The
// result waits in the output register while the next sample is accepted;
// the finishing state stalls only when that register is still occupied. The
// user writes coefficients over the APB port only while the filter is idle;
// the block does not enforce it. b0, b1, b2, a1, a2: bytes 0, 4, 8, 12, 16.
`default_nettype none

module iir_biquad_direct_form_two_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [iirbq_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [iirbq_pkg::DATA_BITS-1:0] pwdata,
  output logic      [iirbq_pkg::DATA_BITS-1:0] prdata,
  output logic                                 pready,
  iirbq_in_if.sink                             in_ch,
  iirbq_out_if.source                          out_ch
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Multiplier operand selects
  localparam logic [2:0] SEL_A1W1 = 3'd0;
  localparam logic [2:0] SEL_A2W2 = 3'd1;
  localparam logic [2:0] SEL_B1W1 = 3'd2;
  localparam logic [2:0] SEL_B2W2 = 3'd3;
  localparam logic [2:0] SEL_B0W  = 3'd4;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [1:0]                state;
  logic [2:0]                step;
  logic signed [iirbq_pkg::SAMPLE_BITS-1:0] x;
  iirbq_pkg::state_t         w1;
  iirbq_pkg::state_t         w2;
  iirbq_pkg::state_t         w;
  iirbq_pkg::acc_t           acc;
  iirbq_pkg::coef_set_t      coefs;
  iirbq_pkg::mac_ctrl_t      mac_ctrl;
  iirbq_pkg::coef_t          mul_coef;
  iirbq_pkg::state_t         mul_operand;
  logic [2:0]                mul_sel;
  logic                      out_valid;
  logic                      in_take;
  logic                      out_load;

  iirbq_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  iirbq_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .coef    (mul_coef),
    .operand (mul_operand),
    .x       (x),
    .acc     (acc)
  );

  // Handshakes
  assign in_ch.ready  = (state == ST_IDLE);
  assign in_take      = in_ch.valid && (state == ST_IDLE);
  assign out_load     = (state == ST_DONE) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;

  // Step decode: multiplier feed and accumulator operation
  always_comb begin
    mul_sel         = SEL_A1W1;
    mac_ctrl.acc_op = iirbq_pkg::ACC_HOLD;
    mac_ctrl.prod_en = (state == ST_RUN);
    if (state == ST_RUN) begin
      unique case (step)
        3'd0: begin
          mul_sel         = SEL_A1W1;
          mac_ctrl.acc_op = iirbq_pkg::ACC_LOAD_X;
        end
        3'd1: begin
          mul_sel         = SEL_A2W2;
          mac_ctrl.acc_op = iirbq_pkg::ACC_SUB_P;
        end
        3'd2: begin
          mul_sel         = SEL_B1W1;
          mac_ctrl.acc_op = iirbq_pkg::ACC_SUB_P;
        end
        3'd3: begin
          mul_sel         = SEL_B2W2;
          mac_ctrl.acc_op = iirbq_pkg::ACC_LOAD_P;
        end
        3'd4: begin
          mul_sel         = SEL_B0W;
          mac_ctrl.acc_op = iirbq_pkg::ACC_ADD_P;
        end
        3'd5: begin
          mul_sel         = SEL_B0W;
          mac_ctrl.acc_op = iirbq_pkg::ACC_ADD_P;
        end
        default: ;
      endcase
    end
  end

  // Operand mux
  always_comb begin
    case (mul_sel)
      SEL_A1W1: begin
        mul_coef    = coefs.a1;
        mul_operand = w1;
      end
      SEL_A2W2: begin
        mul_coef    = coefs.a2;
        mul_operand = w2;
      end
      SEL_B1W1: begin
        mul_coef    = coefs.b1;
        mul_operand = w1;
      end
      SEL_B2W2: begin
        mul_coef    = coefs.b2;
        mul_operand = w2;
      end
      default: begin
        mul_coef    = coefs.b0;
        mul_operand = w;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
          step <= step + 3'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sample capture and intermediate w (accumulator holds w after step 2)
  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= in_ch.sample_in;
    end
    if (state == ST_RUN && step == 3'd3) begin
      w <= iirbq_pkg::sat_state(acc);
    end
  end

  // Delay line shifts when the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= '0;
      w2 <= '0;
    end else if (out_load) begin
      w2 <= w1;
      w1 <= w;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.sample_out <= iirbq_pkg::sat_state(acc);
    end
  end

endmodule

`default_nettype wire
